// ===== design/hcbd_pkg.sv =====
// Shared constants and types of the HTTP chunked body decoder.
`default_nettype none
package hcbd_pkg;

  localparam int SIZE_BITS      = 32;
  localparam int MAX_SIZE_CHARS = 10;
  localparam int CHARS_W        = $clog2(MAX_SIZE_CHARS + 1);
  // width for the first-chunk compare (16-bit value plus 2)
  localparam int CMP_W          = (SIZE_BITS > 17) ? SIZE_BITS : 17;
  localparam int DIGIT_W        = 6;
  localparam int HEX_BASE_SHIFT = 4;   // base 16
  localparam int ALPHA_OFS      = 10;
  localparam int CHECK_OFS      = 2;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CNT_W   = Q_AW + 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2,
    PH_ENDED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_last;
    logic       new_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       body_end;
  } result_t;

  // up to two results written into the result queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r1;
    result_t    r0;
  } wr_req_t;

endpackage
`default_nettype wire

// ===== design/hcbd_in_if.sv =====
// Request channel carrying raw chunked body bytes.
`default_nettype none
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       input_last;
  logic       new_message;

  modport source (output valid, output in_byte, output input_last, output new_message,
                  input ready);
  modport sink   (input valid, input in_byte, input input_last, input new_message,
                  output ready);
endinterface
`default_nettype wire

// ===== design/hcbd_out_if.sv =====
// Request channel carrying decoded results.
`default_nettype none
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       body_end;

  modport source (output valid, output out_byte, output byte_valid, output body_end,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input body_end,
                  output ready);
endinterface
`default_nettype wire

// ===== design/hcbd_step.sv =====
// Parser state and the per-byte decode step of the chunked body decoder.
`default_nettype none
module hcbd_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  hcbd_pkg::in_item_t      item,
  output hcbd_pkg::wr_req_t       wr
);
  import hcbd_pkg::*;

  typedef struct packed {
    phase_t                 phase;
    logic                   cr_pending;
    logic [SIZE_BITS-1:0]   size_value;
    logic [CHARS_W-1:0]     chars_taken;
    logic [SIZE_BITS-1:0]   bytes_left;
    logic                   chunk_start;
    logic                   first_chunk;
    logic [7:0]             held_byte;
    logic                   held_valid;
  } state_t;

  typedef struct packed {
    logic [CHARS_W-1:0]   chars;
    logic [SIZE_BITS-1:0] size;
  } take_t;

  typedef struct packed {
    logic                 emit;
    logic                 chunk_start;
    logic [SIZE_BITS-1:0] bytes_left;
    logic                 to_size;
  } data_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_SIZE,
    cr_pending:  1'b0,
    size_value:  '0,
    chars_taken: '0,
    bytes_left:  '0,
    chunk_start: 1'b0,
    first_chunk: 1'b1,
    held_byte:   8'h00,
    held_valid:  1'b0
  };

  // one size-line character: count it, fold letters and digits into the size
  function automatic take_t take_char(input logic [7:0] b, input logic [CHARS_W-1:0] ch,
                                      input logic [SIZE_BITS-1:0] sz);
    logic [SIZE_BITS+4:0] wide;
    logic [DIGIT_W-1:0]   d;
    logic                 is_val;
    take_t                t;
    t.chars = ch;
    t.size  = sz;
    is_val  = 1'b1;
    d       = '0;
    wide    = '0;
    if (ch < CHARS_W'(MAX_SIZE_CHARS)) begin
      t.chars = ch + CHARS_W'(1);
      if (b >= CH_0 && b <= CH_9) begin
        d = DIGIT_W'(b - CH_0);
      end else if (b >= CH_LA && b <= CH_LZ) begin
        d = DIGIT_W'(b - CH_LA + 8'(ALPHA_OFS));
      end else if (b >= CH_UA && b <= CH_UZ) begin
        d = DIGIT_W'(b - CH_UA + 8'(ALPHA_OFS));
      end else begin
        is_val = 1'b0;
      end
      if (is_val) begin
        wide = ({1'b0, sz, 4'b0000}) + (SIZE_BITS+5)'(d);
        t.size = (wide[SIZE_BITS+4:SIZE_BITS] != '0) ? '1 : wide[SIZE_BITS-1:0];
      end
    end
    return t;
  endfunction

  // one chunk data byte: drop leading zeros, count down the chunk
  function automatic data_t data_step(input logic [7:0] b, input logic cs,
                                      input logic [SIZE_BITS-1:0] bl);
    data_t r;
    r.emit        = !(cs && b == 8'h00);
    r.chunk_start = r.emit ? 1'b0 : cs;
    r.bytes_left  = (bl != '0) ? bl - SIZE_BITS'(1) : bl;
    r.to_size     = (r.bytes_left == '0);
    return r;
  endfunction

  state_t state_r, state_nxt;
  state_t cur;
  take_t  tc1, tc2;
  data_t  ds1, ds2;
  logic   match;
  logic   end_f;
  logic [1:0] p_cnt;
  logic [7:0] p0, p1;
  logic [7:0] b;

  always_comb begin
    b     = item.in_byte;
    cur   = item.new_message ? STATE_RESET : state_r;
    state_nxt = cur;
    p_cnt = 2'd0;
    p0    = 8'h00;
    p1    = 8'h00;
    end_f = 1'b0;
    tc1   = '0;
    tc2   = '0;
    ds1   = '0;
    ds2   = '0;
    match = (CMP_W'(cur.bytes_left) ==
             (CMP_W'({cur.held_byte, b}) + CMP_W'(CHECK_OFS)));
    unique case (cur.phase)
      PH_SIZE: begin
        if (cur.cr_pending) begin
          state_nxt.cr_pending = 1'b0;
          if (b == CH_LF) begin
            if (cur.chars_taken != '0) begin
              // end of size line
              state_nxt.size_value  = '0;
              state_nxt.chars_taken = '0;
              if (cur.size_value == '0) begin
                state_nxt.phase = PH_ENDED;
                end_f = 1'b1;
              end else if (cur.first_chunk) begin
                state_nxt.first_chunk = 1'b0;
                state_nxt.phase       = PH_CHECK;
                state_nxt.bytes_left  = cur.size_value;
                state_nxt.held_valid  = 1'b0;
              end else begin
                state_nxt.phase       = PH_DATA;
                state_nxt.bytes_left  = cur.size_value;
                state_nxt.chunk_start = 1'b1;
              end
            end else begin
              // lone CR LF: LF counts as one ignored character
              tc1 = take_char(CH_LF, cur.chars_taken, cur.size_value);
              state_nxt.chars_taken = tc1.chars;
              state_nxt.size_value  = tc1.size;
            end
          end else begin
            // stray CR counts as a character, then the new byte
            tc1 = take_char(CH_CR, cur.chars_taken, cur.size_value);
            if (b == CH_CR) begin
              state_nxt.cr_pending  = 1'b1;
              state_nxt.chars_taken = tc1.chars;
              state_nxt.size_value  = tc1.size;
            end else begin
              tc2 = take_char(b, tc1.chars, tc1.size);
              state_nxt.chars_taken = tc2.chars;
              state_nxt.size_value  = tc2.size;
            end
          end
        end else if (b == CH_CR) begin
          state_nxt.cr_pending = 1'b1;
        end else begin
          tc1 = take_char(b, cur.chars_taken, cur.size_value);
          state_nxt.chars_taken = tc1.chars;
          state_nxt.size_value  = tc1.size;
        end
      end
      PH_DATA: begin
        ds1 = data_step(b, cur.chunk_start, cur.bytes_left);
        state_nxt.chunk_start = ds1.chunk_start;
        state_nxt.bytes_left  = ds1.bytes_left;
        if (ds1.to_size) begin
          state_nxt.phase       = PH_SIZE;
          state_nxt.cr_pending  = 1'b0;
          state_nxt.size_value  = '0;
          state_nxt.chars_taken = '0;
        end
        if (ds1.emit) begin
          p0    = b;
          p_cnt = 2'd1;
        end
      end
      PH_CHECK: begin
        if (!cur.held_valid) begin
          state_nxt.held_byte  = b;
          state_nxt.held_valid = 1'b1;
        end else begin
          state_nxt.held_valid  = 1'b0;
          state_nxt.phase       = PH_DATA;
          state_nxt.chunk_start = 1'b1;
          if (!match) begin
            // check failed: held byte then this byte go to the chunk
            ds1 = data_step(cur.held_byte, 1'b1, cur.bytes_left);
            state_nxt.chunk_start = ds1.chunk_start;
            state_nxt.bytes_left  = ds1.bytes_left;
            if (ds1.emit) begin
              p0    = cur.held_byte;
              p_cnt = 2'd1;
            end
            if (ds1.to_size) begin
              // chunk used up: this byte opens a fresh size line
              state_nxt.phase       = PH_SIZE;
              state_nxt.cr_pending  = 1'b0;
              state_nxt.size_value  = '0;
              state_nxt.chars_taken = '0;
              if (b == CH_CR) begin
                state_nxt.cr_pending = 1'b1;
              end else begin
                tc1 = take_char(b, '0, '0);
                state_nxt.chars_taken = tc1.chars;
                state_nxt.size_value  = tc1.size;
              end
            end else begin
              ds2 = data_step(b, ds1.chunk_start, ds1.bytes_left);
              state_nxt.chunk_start = ds2.chunk_start;
              state_nxt.bytes_left  = ds2.bytes_left;
              if (ds2.to_size) begin
                state_nxt.phase       = PH_SIZE;
                state_nxt.cr_pending  = 1'b0;
                state_nxt.size_value  = '0;
                state_nxt.chars_taken = '0;
              end
              if (ds2.emit) begin
                if (p_cnt == 2'd0) begin
                  p0 = b;
                end else begin
                  p1 = b;
                end
                p_cnt = p_cnt + 2'd1;
              end
            end
          end
        end
      end
      PH_ENDED: begin
      end
    endcase

    // last byte of the buffer closes the body; a byte held for the check
    // is flushed as the start of the chunk
    if (item.input_last && state_nxt.phase != PH_ENDED) begin
      if (state_nxt.phase == PH_CHECK && state_nxt.held_valid &&
          state_nxt.held_byte != 8'h00) begin
        if (p_cnt == 2'd0) begin
          p0 = state_nxt.held_byte;
        end else begin
          p1 = state_nxt.held_byte;
        end
        p_cnt = p_cnt + 2'd1;
      end
      end_f = 1'b1;
    end
    if (end_f) begin
      state_nxt.phase = PH_ENDED;
    end

    if (end_f && p_cnt == 2'd0) begin
      wr.r0 = '{out_byte: 8'h00, byte_valid: 1'b0, body_end: 1'b1};
      wr.r1 = '0;
      wr.cnt = accept ? 2'd1 : 2'd0;
    end else begin
      wr.r0 = '{out_byte: p0, byte_valid: 1'b1, body_end: end_f && p_cnt == 2'd1};
      wr.r1 = '{out_byte: p1, byte_valid: 1'b1, body_end: end_f};
      wr.cnt = accept ? p_cnt : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/hcbd_outq.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`default_nettype none
module hcbd_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  hcbd_pkg::wr_req_t  wr,
  input  wire logic          pop,
  output logic               has_room,
  output logic               head_valid,
  output hcbd_pkg::result_t  head_data
);
  import hcbd_pkg::*;

  result_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   head_r, head_nxt;
  logic [Q_AW-1:0]   tail_r, tail_nxt;
  logic [Q_AW-1:0]   tail_p1;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    tail_p1    = tail_r + Q_AW'(1);
    tail_nxt   = tail_r + Q_AW'(wr.cnt);
    head_nxt   = pop ? head_r + Q_AW'(1) : head_r;
    count_nxt  = count_r + CNT_W'(wr.cnt) - CNT_W'(pop);
    // room for a two-result request regardless of this cycle's pop
    has_room   = (count_r <= CNT_W'(Q_DEPTH - 2));
    head_valid = (count_r != '0);
    head_data  = mem_r[head_r];
  end

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem_r[tail_r] <= wr.r0;
    end
    if (wr.cnt == 2'd2) begin
      mem_r[tail_p1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/http_chunked_body_decoder_core.sv =====
// HTTP chunked body decoder: raw chunked body bytes in, payload bytes out.
//
// in_ch  : one raw body byte per request, with input_last (last byte of the
//          buffer) and new_message (restart parsing before this byte).
// out_ch : one result per request: out_byte, byte_valid (payload present) and
//          body_end (body closed by a zero-size chunk or by the last byte).
// A raw byte yields zero, one or two results; size-line bytes yield none
// except the result that reports the end of the body.
//
// Results of an accepted byte are written into the result queue and offered
// from its head. Throughput: one byte per cycle while in_ch.ready is high.
// The decode step is a single pass of logic from the accepted byte and parser
// state into a 4-entry result queue; in_ch.ready is high while that queue holds
// 2 or fewer results, and a byte that makes two results fills two entries.
// Stall: when out_ch.ready stays low the queue fills and in_ch.ready drops;
// nothing is lost or repeated.
// Reset (rst_n low, synchronous): queue empty, parser at a first size line.
// After the body ends, bytes are taken and dropped until new_message.
`default_nettype none
module http_chunked_body_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch
);
  import hcbd_pkg::*;

  logic     accept;
  logic     pop;
  logic     has_room;
  logic     head_valid;
  in_item_t item;
  wr_req_t  wr;
  result_t  head_data;

  assign accept = in_ch.valid && has_room;
  assign in_ch.ready = has_room;

  assign item.in_byte     = in_ch.in_byte;
  assign item.input_last  = in_ch.input_last;
  assign item.new_message = in_ch.new_message;

  // parser state and per-byte decode
  hcbd_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .wr     (wr)
  );

  // result queue decouples the two sides
  hcbd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .pop        (pop),
    .has_room   (has_room),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign pop               = head_valid && out_ch.ready;
  assign out_ch.valid      = head_valid;
  assign out_ch.out_byte   = head_data.out_byte;
  assign out_ch.byte_valid = head_data.byte_valid;
  assign out_ch.body_end   = head_data.body_end;

endmodule
`default_nettype wire

// ===== dv/hcbd_payload_checker.sv =====
// Checker for the chunked body decoder: predicts each result request and compares it.
`default_nettype none
module hcbd_payload_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  hcbd_in_if        in_mon,
  hcbd_out_if       out_mon,
  output int        fail_count,
  output int        pending_count
);
  import hcbd_pkg::*;

  localparam logic [7:0]  ASCII_CR  = 8'h0D;
  localparam logic [7:0]  ASCII_LF  = 8'h0A;
  localparam logic [63:0] SIZE_CAP  = (64'd1 << SIZE_BITS) - 1;
  localparam int          MAX_SHOWN = 30;

  // parser state
  phase_t               parse_phase;
  logic                 cr_seen;
  logic [SIZE_BITS-1:0] size_acc;
  int                   size_chars;
  logic [SIZE_BITS-1:0] chunk_left;
  logic                 chunk_head;
  logic                 in_first_chunk;
  logic [7:0]           held_byte;
  logic                 held_ok;

  // results of the byte being decoded
  result_t step_res [2];
  int      step_cnt;
  logic    body_closes;

  result_t pending_payload [$];
  int      mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%0t payload check: %s", $time, msg);
  endtask

  task automatic restart_parser();
    parse_phase    = PH_SIZE;
    cr_seen        = 1'b0;
    size_acc       = '0;
    size_chars     = 0;
    chunk_left     = '0;
    chunk_head     = 1'b0;
    in_first_chunk = 1'b1;
    held_byte      = 8'h00;
    held_ok        = 1'b0;
  endtask

  task automatic open_size_line();
    parse_phase = PH_SIZE;
    cr_seen     = 1'b0;
    size_acc    = '0;
    size_chars  = 0;
  endtask

  task automatic emit_payload(input logic [7:0] b);
    if (step_cnt < 2) begin
      step_res[step_cnt] = '{out_byte: b, byte_valid: 1'b1, body_end: 1'b0};
      step_cnt++;
    end
  endtask

  // Digits and letters (any letter, not just a-f) accumulate base 16.
  task automatic take_size_char(input logic [7:0] c);
    logic [63:0] acc;
    logic [63:0] digit;
    logic        counts;
    if (size_chars >= MAX_SIZE_CHARS) return;
    size_chars++;
    counts = 1'b1;
    digit  = '0;
    if (c >= 8'h30 && c <= 8'h39)      digit = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h7A) digit = c - 8'h61 + 10;
    else if (c >= 8'h41 && c <= 8'h5A) digit = c - 8'h41 + 10;
    else                               counts = 1'b0;
    if (!counts) return;
    acc = 64'(size_acc) * 16 + digit;
    if (acc > SIZE_CAP) acc = SIZE_CAP;
    size_acc = acc[SIZE_BITS-1:0];
  endtask

  task automatic end_size_line();
    logic [SIZE_BITS-1:0] sz;
    sz         = size_acc;
    size_acc   = '0;
    size_chars = 0;
    cr_seen    = 1'b0;
    if (sz == 0) begin
      parse_phase = PH_ENDED;
      body_closes = 1'b1;
    end else if (in_first_chunk) begin
      in_first_chunk = 1'b0;
      parse_phase    = PH_CHECK;
      chunk_left     = sz;
      held_ok        = 1'b0;
    end else begin
      parse_phase = PH_DATA;
      chunk_left  = sz;
      chunk_head  = 1'b1;
    end
  endtask

  task automatic size_line_byte(input logic [7:0] c);
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (c == ASCII_LF) begin
        if (size_chars > 0) end_size_line();
        else take_size_char(c);
        return;
      end
      take_size_char(ASCII_CR);
    end
    if (c == ASCII_CR) cr_seen = 1'b1;
    else take_size_char(c);
  endtask

  task automatic chunk_data_byte(input logic [7:0] c);
    if (!(chunk_head && c == 8'h00)) begin
      chunk_head = 1'b0;
      emit_payload(c);
    end
    if (chunk_left > 0) chunk_left--;
    if (chunk_left == 0) open_size_line();
  endtask

  // First chunk: a 2-byte big-endian length equal to size - 2 is stripped.
  task automatic prefix_check_byte(input logic [7:0] c);
    logic [63:0] marker;
    if (!held_ok) begin
      held_byte = c;
      held_ok   = 1'b1;
      return;
    end
    held_ok     = 1'b0;
    marker      = {48'd0, held_byte, c};
    parse_phase = PH_DATA;
    chunk_head  = 1'b1;
    if (chunk_left >= 2 && 64'(chunk_left) - 2 == marker) return;
    chunk_data_byte(held_byte);
    if (parse_phase == PH_SIZE) size_line_byte(c);
    else chunk_data_byte(c);
  endtask

  task automatic decode_raw_byte(input logic [7:0] c, input logic last, input logic restart);
    step_cnt    = 0;
    body_closes = 1'b0;
    if (restart) restart_parser();
    if (parse_phase == PH_ENDED) return;
    case (parse_phase)
      PH_SIZE:  size_line_byte(c);
      PH_DATA:  chunk_data_byte(c);
      PH_CHECK: prefix_check_byte(c);
      default:  ;
    endcase
    if (last && parse_phase != PH_ENDED) begin
      if (parse_phase == PH_CHECK && held_ok) begin
        held_ok     = 1'b0;
        parse_phase = PH_DATA;
        chunk_head  = 1'b1;
        chunk_data_byte(held_byte);
      end
      parse_phase = PH_ENDED;
      body_closes = 1'b1;
    end
    if (body_closes) begin
      parse_phase = PH_ENDED;
      if (step_cnt == 0) begin
        step_res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, body_end: 1'b1};
        step_cnt    = 1;
      end else begin
        step_res[step_cnt-1].body_end = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    int      k;
    if (!rst_n) begin
      restart_parser();
      pending_payload.delete();
    end else begin
      // results of a byte show up no earlier than the cycle after it is taken: compare first
      if (out_mon.valid && out_mon.ready) begin
        if (pending_payload.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h valid %0b end %0b",
                                    out_mon.out_byte, out_mon.byte_valid, out_mon.body_end));
        end else begin
          want = pending_payload.pop_front();
          if (out_mon.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_mon.out_byte, want.out_byte));
          if (out_mon.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                      out_mon.byte_valid, want.byte_valid));
          if (out_mon.body_end !== want.body_end)
            report_mismatch($sformatf("body_end %0b, expected %0b",
                                      out_mon.body_end, want.body_end));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_raw_byte(in_mon.in_byte, in_mon.input_last, in_mon.new_message);
        for (k = 0; k < step_cnt; k++) pending_payload.push_back(step_res[k]);
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_payload.size();
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench top for the chunked body decoder: clock, reset, byte stimulus and verdict.
`default_nettype none
module testbench;

  localparam int         CLK_HALF     = 5;
  localparam int         RESET_CYCLES = 11;
  localparam int         TARGET_BYTES = 950;
  localparam int         HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int         DRAIN_CYCLES = 20;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [7:0] ASCII_CR     = 8'h0D;
  localparam logic [7:0] ASCII_LF     = 8'h0A;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;            // sender gap chance, owned by the stimulus process
  int   stall_pct;           // receiver stall chance, written with NBAs
  logic hold_req;            // asks the receiver for one long hold-off
  logic restart_next;        // new_message flag for the next request
  int   bytes_sent  = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_count;

  hcbd_in_if  in_ch ();
  hcbd_out_if out_ch ();

  http_chunked_body_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hcbd_payload_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("http_chunked_body_decoder_core regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off once requested so the
  // decoder's result queue fills and it pushes back on the byte channel.
  initial begin : result_drain
    int   held_off;
    logic hold_done;
    held_off  = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        held_off++;
        if (held_off == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One raw byte request; random gaps before it, returns right after the
  // accepting edge with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.input_last  <= last;
    in_ch.new_message <= restart_next;
    restart_next = 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_crlf();
    send_byte(ASCII_CR, 1'b0);
    send_byte(ASCII_LF, 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // One random message. Mostly well-formed chunked bodies with random
  // content; some are noise, some overflow the size, some are cut short.
  task automatic send_message();
    logic [7:0] raw [$];
    logic [7:0] ch;
    logic       upper;
    int         kind, n_chunks, sz, n_zero, cut, pick, i, c;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise: arbitrary bytes and flags
      repeat ($urandom_range(4, 16)) begin
        restart_next = ($urandom_range(0, 19) == 0);
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
      return;
    end
    n_chunks = $urandom_range(1, 4);
    if (kind < 20) begin
      // size far past 32 bits and past the size-line character limit
      repeat (12) raw.push_back($urandom_range(0, 1) ? 8'h46 : 8'h66);
      raw.push_back(ASCII_CR);
      raw.push_back(ASCII_LF);
      repeat (5) raw.push_back(8'($urandom_range(0, 255)));
      n_chunks = 0;
    end
    for (c = 0; c < n_chunks; c++) begin
      pick  = $urandom_range(0, 99);
      upper = 1'($urandom_range(0, 1));
      if (pick < 12) begin
        // letters beyond f still count, as 16..35
        ch = 8'($urandom_range(8'h67, 8'h7A));
        sz = ch - 8'h67 + 16;
        raw.push_back(upper ? ch - 8'h20 : ch);
      end else begin
        sz = (pick < 80) ? $urandom_range(1, 12) : $urandom_range(13, 60);
        repeat ($urandom_range(0, 2)) raw.push_back(8'h30);
        if (sz > 15) raw.push_back(hex_char(sz[7:4], upper));
        raw.push_back(hex_char(sz[3:0], upper));
      end
      // extension-like junk is taken but adds nothing
      if ($urandom_range(0, 9) == 0) raw.push_back(8'h3B);
      raw.push_back(ASCII_CR);
      raw.push_back(ASCII_LF);
      if (c == 0 && sz >= 2 && $urandom_range(0, 1)) begin
        raw.push_back(8'((sz - 2) >> 8));
        raw.push_back(8'(sz - 2));
      end
      n_zero = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (sz < 3) ? sz : 3) : 0;
      for (i = 0; i < sz; i++) raw.push_back((i < n_zero) ? 8'h00 : 8'($urandom_range(0, 255)));
      raw.push_back(ASCII_CR);
      raw.push_back(ASCII_LF);
    end
    raw.push_back(8'h30);
    raw.push_back(ASCII_CR);
    raw.push_back(ASCII_LF);
    raw.push_back(ASCII_CR);
    raw.push_back(ASCII_LF);

    if (kind < 20)      cut = raw.size() - 1;                  // huge chunk never completes
    else if (kind < 30) cut = $urandom_range(0, raw.size() - 1); // buffer ends mid-message
    else                cut = $urandom_range(0, 1) ? raw.size() - 1 : raw.size();
    restart_next = ($urandom_range(0, 9) != 0);
    for (i = 0; i < raw.size() && i <= cut; i++) send_byte(raw[i], i == cut);
  endtask

  initial begin : byte_feed
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.input_last  <= 1'b0;
    in_ch.new_message <= 1'b0;
    hold_req          <= 1'b0;
    stall_pct         <= 72;
    idle_pct     = 13;
    restart_next = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // lone CR LF, size 4 with a stray CR and a junk char in the line
    restart_next = 1'b1;
    send_crlf();
    send_byte(8'h34, 1'b0);
    send_byte(ASCII_CR, 1'b0);
    send_byte(8'h2D, 1'b0);
    send_crlf();
    // length prefix equal to size - 2 is stripped; leading zero dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_crlf();
    // zero-size chunk: end reported on its own, then bytes are ignored
    send_byte(8'h30, 1'b0);
    send_crlf();
    send_byte(8'h41, 1'b0);
    // prefix mismatch releases two payload bytes from one request
    restart_next = 1'b1;
    send_byte(8'h33, 1'b0);
    send_crlf();
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    // last byte is the first byte of the prefix check, so it is held and flushed
    restart_next = 1'b1;
    send_byte(8'h35, 1'b0);
    send_crlf();
    send_byte(8'h99, 1'b1);

    // random messages; idling swaps sides, then stops with one long hold-off
    while (bytes_sent < TARGET_BYTES) begin
      if (bytes_sent >= 2 * TARGET_BYTES / 3) begin
        idle_pct = 0;
        stall_pct <= 0;
        hold_req  <= 1'b1;
      end else if (bytes_sent >= TARGET_BYTES / 3) begin
        idle_pct = 72;
        stall_pct <= 13;
      end
      send_message();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_chunked_body_decoder_core regression: pass");
    end else begin
      $display("http_chunked_body_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
